// ===== sv/dsched_pkg.sv =====
package dsched_pkg;

  // Operation codes carried by the request channel.
  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_SELECT = 1'b1;

  // Scheduling policy codes. Codes above POL_FLOOK behave as FIFO.
  localparam logic [2:0] POL_FIFO  = 3'd0;
  localparam logic [2:0] POL_SSTF  = 3'd1;
  localparam logic [2:0] POL_LOOK  = 3'd2;
  localparam logic [2:0] POL_CLOOK = 3'd3;
  localparam logic [2:0] POL_FLOOK = 3'd4;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Control from the sequencer to the candidate tracker.
  typedef struct packed {
    logic clear;      // start of a new select
    logic sample;     // read data holds a valid entry this cycle
    logic flook;      // only entries of the active batch are direction candidates
    logic act_epoch;  // batch mark that currently means "active"
  } pick_ctrl_t;

endpackage

// ===== sv/dsched_if.sv =====
// Request channel: add or select transactions.
interface dsched_req_if #(
  parameter int ID_BITS    = 16,
  parameter int TRACK_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic                  opcode;
  logic [ID_BITS-1:0]    req_id;
  logic [TRACK_BITS-1:0] req_track;
  logic [TRACK_BITS-1:0] head_track;

  modport source (output valid, opcode, req_id, req_track, head_track, input ready);
  modport sink   (input valid, opcode, req_id, req_track, head_track, output ready);
endinterface

// Response channel: one result transaction per request.
interface dsched_rsp_if #(
  parameter int ID_BITS    = 16,
  parameter int TRACK_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic [1:0]            status;
  logic [ID_BITS-1:0]    chosen_id;
  logic [TRACK_BITS-1:0] chosen_track;
  logic                  idle;

  modport source (output valid, status, chosen_id, chosen_track, idle, input ready);
  modport sink   (input valid, status, chosen_id, chosen_track, idle, output ready);
endinterface

// Configuration channel: writes the policy register.
interface dsched_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] policy;

  modport source (output valid, policy, input ready);
  modport sink   (input valid, policy, output ready);
endinterface

// ===== sv/dsched_pick.sv =====
module dsched_pick #(
  parameter int IDX_W      = 6,
  parameter int TRACK_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  dsched_pkg::pick_ctrl_t ctrl,
  input  logic [2:0]             policy,
  input  logic                   sweep_up,
  input  logic [TRACK_BITS-1:0]  head,
  input  logic [IDX_W-1:0]       ent_idx,
  input  logic [TRACK_BITS-1:0]  ent_track,
  input  logic                   ent_mark,
  output logic [IDX_W-1:0]       pick_idx,
  output logic                   flip
);
  import dsched_pkg::*;

  logic                  at_or_above;
  logic                  at_or_below;
  logic                  elig;
  logic [TRACK_BITS-1:0] trk_gap;

  // Best candidates seen so far: overall nearest, nearest upward,
  // nearest downward and lowest track. Strict compares keep the oldest on ties.
  logic                  all_v, up_v, dn_v, min_v;
  logic [TRACK_BITS-1:0] all_d, up_d, dn_d, min_t;
  logic [IDX_W-1:0]      all_i, up_i, dn_i, min_i;

  // Distance of the entry under inspection from the head.
  always_comb begin
    at_or_above = (ent_track >= head);
    at_or_below = (ent_track <= head);
    trk_gap     = at_or_above ? (ent_track - head) : (head - ent_track);
    elig        = !ctrl.flook || (ent_mark == ctrl.act_epoch);
  end

  // Candidate registers, updated once per scanned entry.
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      all_v <= 1'b0;
      up_v  <= 1'b0;
      dn_v  <= 1'b0;
      min_v <= 1'b0;
    end else if (ctrl.sample) begin
      if (!all_v || trk_gap < all_d) begin
        all_v <= 1'b1;
        all_d <= trk_gap;
        all_i <= ent_idx;
      end
      if (at_or_above && elig && (!up_v || trk_gap < up_d)) begin
        up_v <= 1'b1;
        up_d <= trk_gap;
        up_i <= ent_idx;
      end
      if (at_or_below && elig && (!dn_v || trk_gap < dn_d)) begin
        dn_v <= 1'b1;
        dn_d <= trk_gap;
        dn_i <= ent_idx;
      end
      if (!min_v || ent_track < min_t) begin
        min_v <= 1'b1;
        min_t <= ent_track;
        min_i <= ent_idx;
      end
    end
  end

  // Final choice by policy once the scan is over.
  always_comb begin
    pick_idx = '0;
    flip     = 1'b0;
    case (policy)
      POL_SSTF: begin
        pick_idx = all_i;
      end
      POL_LOOK, POL_FLOOK: begin
        if (sweep_up) begin
          flip = !up_v;
          if (up_v) begin
            pick_idx = up_i;
          end else if (dn_v) begin
            pick_idx = dn_i;
          end
        end else begin
          flip = !dn_v;
          if (dn_v) begin
            pick_idx = dn_i;
          end else if (up_v) begin
            pick_idx = up_i;
          end
        end
      end
      POL_CLOOK: begin
        pick_idx = up_v ? up_i : min_i;
      end
      default: begin
        pick_idx = '0;
      end
    endcase
  end

endmodule

// ===== sv/disk_request_scheduler_core.sv =====
// Disk request scheduler. Requests (id, track) are held in one on-chip memory,
// packed in arrival order. An add answers at once. A select over n pending
// requests scans the memory one entry per cycle through its single read port,
// then reads the chosen entry and moves every younger entry down one place.
// Policy is FIFO, SSTF, LOOK, C-LOOK or F-LOOK, set through the configuration
// channel; the user must write it only while no transaction is in flight, as the
// block itself does not enforce this. F-LOOK batches are tracked by a one-bit
// mark per entry and an active-batch epoch, so a batch swap needs no pass over
// the store. An add to a full store answers with status full and is dropped.
module disk_request_scheduler_core #(
  parameter int QUEUE_DEPTH = 64,
  parameter int TRACK_BITS  = 16,
  parameter int ID_BITS     = 16
) (
  input  logic        clk,
  input  logic        rst,
  dsched_req_if.sink  req,
  dsched_rsp_if.source rsp,
  dsched_cfg_if.sink  cfg
);
  import dsched_pkg::*;

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [ID_BITS-1:0]    id;
    logic [TRACK_BITS-1:0] track;
    logic                  mark;
  } entry_t;

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_PICK, S_SHIFT, S_FIN} state_t;

  state_t                st;
  logic [2:0]            policy;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      act_count;
  logic                  act_epoch;
  logic                  sweep_up;
  logic [TRACK_BITS-1:0] head;
  logic [CNT_W-1:0]      scan_i;
  logic                  ev_v;
  logic [IDX_W-1:0]      ev_idx;
  logic [CNT_W-1:0]      sh_i;
  logic                  rd_pend;
  logic [IDX_W-1:0]      rd_idx;
  logic                  first;
  logic [ID_BITS-1:0]    ch_id;
  logic [TRACK_BITS-1:0] ch_track;
  logic                  ov;
  logic [1:0]            o_status;
  logic [ID_BITS-1:0]    o_id;
  logic [TRACK_BITS-1:0] o_track;
  logic                  o_idle;

  entry_t                mem [QUEUE_DEPTH];
  entry_t                rdata;
  entry_t                mem_wd;
  logic                  mem_we;
  logic [IDX_W-1:0]      mem_wa;
  logic [IDX_W-1:0]      mem_ra;

  logic                  out_free;
  logic                  in_fire;
  logic                  not_full;
  pick_ctrl_t            pctrl;
  logic [IDX_W-1:0]      pick_idx;
  logic                  flip;

  // Handshakes.
  assign out_free   = !ov || rsp.ready;
  assign req.ready  = (st == S_IDLE) && out_free;
  assign in_fire    = req.valid && req.ready;
  assign cfg.ready  = 1'b1;
  assign not_full   = (count < CNT_W'(QUEUE_DEPTH));

  assign rsp.valid        = ov;
  assign rsp.status       = o_status;
  assign rsp.chosen_id    = o_id;
  assign rsp.chosen_track = o_track;
  assign rsp.idle         = o_idle;

  // Memory port steering: adds write at the tail, the shift pass writes one below.
  always_comb begin
    case (st)
      S_SCAN:  mem_ra = scan_i[IDX_W-1:0];
      S_PICK:  mem_ra = pick_idx;
      S_SHIFT: mem_ra = sh_i[IDX_W-1:0];
      default: mem_ra = '0;
    endcase
    if (st == S_SHIFT) begin
      mem_we = rd_pend && !first;
      mem_wa = IDX_W'(rd_idx - 1'b1);
      mem_wd = rdata;
    end else begin
      mem_we = in_fire && (req.opcode == OP_ADD) && not_full;
      mem_wa = count[IDX_W-1:0];
      mem_wd = '{id: req.req_id, track: req.req_track, mark: ~act_epoch};
    end
  end

  // Request store, one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata <= mem[mem_ra];
  end

  // Candidate tracker control.
  always_comb begin
    pctrl.clear     = in_fire;
    pctrl.sample    = (st == S_SCAN) && ev_v;
    pctrl.flook     = (policy == POL_FLOOK);
    pctrl.act_epoch = act_epoch;
  end

  dsched_pick #(
    .IDX_W      (IDX_W),
    .TRACK_BITS (TRACK_BITS)
  ) u_pick (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (pctrl),
    .policy    (policy),
    .sweep_up  (sweep_up),
    .head      (head),
    .ent_idx   (ev_idx),
    .ent_track (rdata.track),
    .ent_mark  (rdata.mark),
    .pick_idx  (pick_idx),
    .flip      (flip)
  );

  // Sequencer, configuration register and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_IDLE;
      policy    <= POL_FIFO;
      count     <= '0;
      act_count <= '0;
      act_epoch <= 1'b0;
      sweep_up  <= 1'b1;
      scan_i    <= '0;
      ev_v      <= 1'b0;
      sh_i      <= '0;
      rd_pend   <= 1'b0;
      first     <= 1'b0;
      ov        <= 1'b0;
    end else begin
      if (cfg.valid) begin
        policy <= cfg.policy;
      end
      if (ov && rsp.ready) begin
        ov <= 1'b0;
      end
      case (st)
        S_IDLE: begin
          if (in_fire) begin
            if (req.opcode == OP_ADD) begin
              ov      <= 1'b1;
              o_id    <= '0;
              o_track <= '0;
              o_idle  <= 1'b0;
              if (not_full) begin
                count    <= CNT_W'(count + 1'b1);
                o_status <= ST_OK;
              end else begin
                o_status <= ST_FULL;
              end
            end else if (count == '0) begin
              ov       <= 1'b1;
              o_status <= ST_EMPTY;
              o_id     <= '0;
              o_track  <= '0;
              o_idle   <= 1'b1;
            end else begin
              head   <= req.head_track;
              scan_i <= '0;
              ev_v   <= 1'b0;
              st     <= S_SCAN;
              // Active batch exhausted: the waiting batch becomes active.
              if (policy == POL_FLOOK && act_count == '0) begin
                act_epoch <= ~act_epoch;
                sweep_up  <= 1'b1;
                act_count <= count;
              end
            end
          end
        end
        S_SCAN: begin
          if (scan_i < count) begin
            scan_i <= CNT_W'(scan_i + 1'b1);
            ev_v   <= 1'b1;
            ev_idx <= scan_i[IDX_W-1:0];
          end else begin
            ev_v <= 1'b0;
            if (!ev_v) begin
              st <= S_PICK;
            end
          end
        end
        S_PICK: begin
          if (flip) begin
            sweep_up <= ~sweep_up;
          end
          sh_i    <= CNT_W'(CNT_W'(pick_idx) + 1'b1);
          rd_pend <= 1'b1;
          rd_idx  <= pick_idx;
          first   <= 1'b1;
          st      <= S_SHIFT;
        end
        S_SHIFT: begin
          // First read returns the chosen entry; later reads move down one place.
          if (rd_pend && first) begin
            ch_id    <= rdata.id;
            ch_track <= rdata.track;
            if (rdata.mark == act_epoch) begin
              act_count <= CNT_W'(act_count - 1'b1);
            end
          end
          first <= 1'b0;
          if (sh_i < count) begin
            rd_pend <= 1'b1;
            rd_idx  <= sh_i[IDX_W-1:0];
            sh_i    <= CNT_W'(sh_i + 1'b1);
          end else begin
            rd_pend <= 1'b0;
          end
          if (!rd_pend) begin
            count <= CNT_W'(count - 1'b1);
            st    <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            ov       <= 1'b1;
            o_status <= ST_OK;
            o_id     <= ch_id;
            o_track  <= ch_track;
            o_idle   <= (count == '0);
            st       <= S_IDLE;
          end
        end
        default: begin
          st <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== sv/dsched_check.sv =====
module dsched_check #(
  parameter int ID_BITS    = 16,
  parameter int TRACK_BITS = 16
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  rsp_valid,
  input logic                  rsp_ready,
  input logic [1:0]            status,
  input logic [ID_BITS-1:0]    chosen_id,
  input logic [TRACK_BITS-1:0] chosen_track,
  input logic                  idle
);
  import dsched_pkg::*;

  // A stalled result transaction keeps its contents.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(chosen_id)
      && $stable(chosen_track) && $stable(idle))
    else $error("result changed while stalled");

  // Only defined status codes are reported.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (status == ST_OK || status == ST_EMPTY || status == ST_FULL))
    else $error("undefined status code");

  // An empty select leaves the store idle and reports no request.
  a_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == ST_EMPTY |-> idle && chosen_id == '0 && chosen_track == '0)
    else $error("empty select reported a request");

  // A dropped add means the store is full, so it cannot be idle.
  a_full: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == ST_FULL |-> !idle && chosen_id == '0 && chosen_track == '0)
    else $error("full status with idle store or request fields");

endmodule

bind disk_request_scheduler_core dsched_check #(
  .ID_BITS    (ID_BITS),
  .TRACK_BITS (TRACK_BITS)
) u_dsched_check (
  .clk          (clk),
  .rst          (rst),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .status       (rsp.status),
  .chosen_id    (rsp.chosen_id),
  .chosen_track (rsp.chosen_track),
  .idle         (rsp.idle)
);

// ===== sim/tb_disk_request_scheduler_core.sv =====
module tb_disk_request_scheduler_core;
  import dsched_pkg::*;

  localparam int DEPTH       = 64;
  localparam int ID_W        = 16;
  localparam int TRK_W       = 16;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 30;

  // Policy codes with no scheduler of their own; the block treats them as FIFO.
  localparam logic [2:0] POL_SPARE_LO  = 3'd5;
  localparam logic [2:0] POL_SPARE_MID = 3'd6;
  localparam logic [2:0] POL_SPARE_HI  = 3'd7;

  localparam logic [2:0] PHASE_POLICY [PHASES] = '{
    POL_SSTF, POL_LOOK, POL_CLOOK, POL_FLOOK, POL_SPARE_HI, POL_FIFO,
    POL_SPARE_LO, POL_SPARE_MID, POL_FLOOK, POL_LOOK, POL_SSTF, POL_CLOOK
  };

  typedef struct packed {
    logic             op;
    logic [ID_W-1:0]  id;
    logic [TRK_W-1:0] track;
    logic [TRK_W-1:0] head;
  } sched_req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [ID_W-1:0]  id;
    logic [TRK_W-1:0] track;
    logic             idle;
  } sched_rsp_t;

  logic clk = 1'b0;
  logic rst;

  dsched_req_if #(.ID_BITS(ID_W), .TRACK_BITS(TRK_W)) req_ch ();
  dsched_rsp_if #(.ID_BITS(ID_W), .TRACK_BITS(TRK_W)) rsp_ch ();
  dsched_cfg_if cfg_ch ();

  disk_request_scheduler_core #(
    .QUEUE_DEPTH(DEPTH),
    .TRACK_BITS (TRK_W),
    .ID_BITS    (ID_W)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg(cfg_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow copy of the pending-request store, kept in arrival order.
  logic [ID_W-1:0]  store_id     [DEPTH];
  logic [TRK_W-1:0] store_track  [DEPTH];
  bit               store_active [DEPTH];
  int               store_count = 0;
  bit               sweep_up    = 1'b1;
  logic [2:0]       policy      = POL_FIFO;

  sched_req_t  req_backlog [$];
  sched_rsp_t  rsp_due [$];
  int unsigned queued       = 0;
  int unsigned answered     = 0;
  int unsigned errors       = 0;
  int unsigned send_gap_pct = 0;
  int unsigned stall_pct    = 0;
  int unsigned hold_left    = 0;
  logic        hold_kick    = 1'b0;
  int          planned_fill = 0;

  function automatic logic [TRK_W-1:0] track_gap(logic [TRK_W-1:0] a, logic [TRK_W-1:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

  // Nearest stored track on one side of the head; -1 when that side is empty.
  function automatic int nearest_toward(logic [TRK_W-1:0] head, bit up, bit active_only);
    int               best;
    logic [TRK_W-1:0] best_gap;
    logic [TRK_W-1:0] gap;
    bit               ok;
    best     = -1;
    best_gap = '0;
    for (int i = 0; i < store_count; i++) begin
      ok  = up ? (store_track[i] >= head) : (store_track[i] <= head);
      ok  = ok && (!active_only || store_active[i]);
      gap = track_gap(store_track[i], head);
      if (ok && (best < 0 || gap < best_gap)) begin
        best     = i;
        best_gap = gap;
      end
    end
    return best;
  endfunction

  // Sweep pick: keep the direction if anything lies ahead, otherwise turn around.
  function automatic int sweep_pick(logic [TRK_W-1:0] head, bit active_only);
    int pick;
    pick = nearest_toward(head, sweep_up, active_only);
    if (pick < 0) begin
      sweep_up = !sweep_up;
      pick     = nearest_toward(head, sweep_up, active_only);
    end
    return pick;
  endfunction

  // Applies one request to the shadow store and returns the response it earns.
  function automatic sched_rsp_t serve_request(sched_req_t r);
    sched_rsp_t       res;
    int               pick;
    bit               any_active;
    logic [TRK_W-1:0] best_gap;
    res        = '0;
    res.status = ST_OK;
    if (r.op == OP_ADD) begin
      if (store_count >= DEPTH) begin
        res.status = ST_FULL;
      end else begin
        store_id[store_count]     = r.id;
        store_track[store_count]  = r.track;
        store_active[store_count] = 1'b0;
        store_count++;
      end
    end else if (store_count == 0) begin
      res.status = ST_EMPTY;
    end else begin
      pick = 0;
      case (policy)
        POL_SSTF: begin
          best_gap = track_gap(store_track[0], r.head);
          for (int i = 1; i < store_count; i++) begin
            if (track_gap(store_track[i], r.head) < best_gap) begin
              pick     = i;
              best_gap = track_gap(store_track[i], r.head);
            end
          end
        end
        POL_LOOK: begin
          pick = sweep_pick(r.head, 1'b0);
        end
        POL_CLOOK: begin
          pick = nearest_toward(r.head, 1'b1, 1'b0);
          if (pick < 0) begin
            pick = 0;
            for (int i = 1; i < store_count; i++) begin
              if (store_track[i] < store_track[pick]) pick = i;
            end
          end
        end
        POL_FLOOK: begin
          // An empty active batch swaps in everything waiting and restarts upward.
          any_active = 1'b0;
          for (int i = 0; i < store_count; i++) any_active |= store_active[i];
          if (!any_active) begin
            for (int i = 0; i < store_count; i++) store_active[i] = 1'b1;
            sweep_up = 1'b1;
          end
          pick = sweep_pick(r.head, 1'b1);
        end
        default: begin
          pick = 0;
        end
      endcase
      if (pick < 0) pick = 0;
      res.id    = store_id[pick];
      res.track = store_track[pick];
      for (int i = pick; i + 1 < store_count; i++) begin
        store_id[i]     = store_id[i + 1];
        store_track[i]  = store_track[i + 1];
        store_active[i] = store_active[i + 1];
      end
      store_count--;
    end
    res.idle = (store_count == 0);
    return res;
  endfunction

  function automatic void flag_mismatch(string what, sched_rsp_t want, sched_rsp_t got);
    errors++;
    if (errors <= 10) begin
      $display("mismatch (%s): expected status %0d id %h track %h idle %0d", what,
               want.status, want.id, want.track, want.idle);
      $display("                got      status %0d id %h track %h idle %0d",
               got.status, got.id, got.track, got.idle);
    end
  endfunction

  // Tracks cluster around a per-phase center so that ties and reversals are common.
  function automatic logic [TRK_W-1:0] rand_track(int unsigned center);
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return TRK_W'($urandom());
      default: return TRK_W'(center + $urandom_range(15));
    endcase
  endfunction

  task automatic queue_item(input logic op, input logic [ID_W-1:0] id,
                            input logic [TRK_W-1:0] trk, input logic [TRK_W-1:0] head);
    sched_req_t item;
    item        = {op, id, trk, head};
    req_backlog = {req_backlog, item};
    queued++;
    if (op == OP_ADD && planned_fill < DEPTH) planned_fill++;
    if (op == OP_SELECT && planned_fill > 0) planned_fill--;
  endtask

  // Waits until every queued transaction has been answered, then lets the block settle.
  task automatic wait_drained();
    @(posedge clk);
    while (answered != queued) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes the policy register; must be called right after a rising edge.
  task automatic set_policy(input logic [2:0] code);
    cfg_ch.policy <= code;
    cfg_ch.valid  <= 1'b1;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    policy = code;
  endtask

  // Request driver: offers the backlog with random gaps.
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_ch.ready) begin
      if (req_backlog.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        req_ch.opcode     <= req_backlog[0].op;
        req_ch.req_id     <= req_backlog[0].id;
        req_ch.req_track  <= req_backlog[0].track;
        req_ch.head_track <= req_backlog[0].head;
        req_ch.valid      <= 1'b1;
        req_backlog.delete(0);
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Long hold-off of the response side, counted down on its own.
  always @(posedge clk) begin
    if (hold_kick) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Response ready with random stalls.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
    end
  end

  // Monitor: predicts on each accepted request, then checks each accepted response.
  always @(posedge clk) begin : monitor
    sched_rsp_t got;
    sched_rsp_t want;
    sched_rsp_t due;
    if (!rst) begin
      if (req_ch.valid && req_ch.ready) begin
        due     = serve_request({req_ch.opcode, req_ch.req_id,
                                 req_ch.req_track, req_ch.head_track});
        rsp_due = {rsp_due, due};
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        answered++;
        got = {rsp_ch.status, rsp_ch.chosen_id, rsp_ch.chosen_track, rsp_ch.idle};
        if (rsp_due.size() == 0) begin
          flag_mismatch("no response expected", '0, got);
        end else begin
          want = rsp_due[0];
          rsp_due.delete(0);
          if (got.status != want.status || got.id != want.id ||
              got.track != want.track || got.idle != want.idle) begin
            flag_mismatch("field", want, got);
          end
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned cluster;
    int unsigned add_pct;
    int          run_left;
    rst           = 1'b1;
    cfg_ch.valid  = 1'b0;
    cfg_ch.policy = POL_FIFO;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed part under the reset policy: empty selects, field extremes, equal tracks.
    queue_item(OP_SELECT, '0, '0, '0);
    queue_item(OP_SELECT, '1, '1, '1);
    queue_item(OP_ADD, '0, '0, '1);
    queue_item(OP_ADD, '1, '1, '0);
    queue_item(OP_ADD, 16'h5555, 16'h8000, 16'h1234);
    queue_item(OP_ADD, 16'hAAAA, 16'h8000, 16'hEDCB);
    queue_item(OP_ADD, 16'h0001, 16'h7FFF, 16'h8000);
    queue_item(OP_SELECT, 16'h0F0F, 16'hF0F0, '1);
    queue_item(OP_SELECT, 16'hF0F0, 16'h0F0F, '0);
    queue_item(OP_SELECT, '0, '0, 16'h8000);
    queue_item(OP_SELECT, '0, '0, 16'h7FFF);
    queue_item(OP_SELECT, '0, '0, 16'h0001);
    queue_item(OP_SELECT, '0, '0, 16'hFFFE);

    // Random phases, one policy each; the store carries over from phase to phase.
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      set_policy(PHASE_POLICY[ph]);
      case (ph % 4)
        0:       begin send_gap_pct = 0;  stall_pct = 0;  end
        1:       begin send_gap_pct = 63; stall_pct = 0;  end
        2:       begin send_gap_pct = 0;  stall_pct = 63; end
        default: begin send_gap_pct = 6;  stall_pct = 6;  end
      endcase
      cluster = $urandom_range(16'hFFF0);

      // In phases 3 and 9, fill the store to the brim, overflow it, then drain it past empty.
      if (PHASE_POLICY[ph] == POL_FLOOK || PHASE_POLICY[ph] == POL_LOOK) begin
        if (ph == 3 || ph == 9) begin
          while (planned_fill < DEPTH) begin
            queue_item(OP_ADD, ID_W'($urandom()), rand_track(cluster), rand_track(cluster));
          end
          repeat (2) queue_item(OP_ADD, ID_W'($urandom()), rand_track(cluster), '0);
          while (planned_fill > 0) begin
            queue_item(OP_SELECT, ID_W'($urandom()), rand_track(cluster),
                       rand_track(cluster));
          end
          queue_item(OP_SELECT, '0, '0, rand_track(cluster));
        end
      end

      // Runs of add-heavy, select-heavy and balanced traffic.
      run_left = 0;
      add_pct  = 55;
      repeat (PHASE_ITEMS) begin
        if (run_left == 0) begin
          case ($urandom_range(2))
            0:       add_pct = 80;
            1:       add_pct = 25;
            default: add_pct = 55;
          endcase
          run_left = $urandom_range(4, 20);
        end
        run_left--;
        queue_item(($urandom_range(99) < add_pct) ? OP_ADD : OP_SELECT, ID_W'($urandom()),
                   rand_track(cluster), rand_track(cluster));
      end

      // Hold the response side off while requests keep coming.
      if (ph == 0) begin
        hold_kick <= 1'b1;
        @(posedge clk);
        hold_kick <= 1'b0;
      end
    end

    wait_drained();
    repeat (200) @(posedge clk);
    while (rsp_due.size() != 0) begin
      flag_mismatch("response never arrived", rsp_due[0], '0);
      rsp_due.delete(0);
    end
    if (errors == 0) begin
      $display("tb_disk_request_scheduler_core: done, clean");
    end else begin
      $display("tb_disk_request_scheduler_core: done, errors");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #4000000;
    $display("tb_disk_request_scheduler_core: done, errors");
    $finish;
  end

endmodule
